/* sv/teq_pkg.sv */
// ----------------------------------------------------------------------------
// Timer expiry queue package
// Shared types and constants for the timer expiry queue cell chain.
// ----------------------------------------------------------------------------
`default_nettype none
package teq_pkg;
    localparam int unsigned DEPTH_DEF = 16;
    localparam int unsigned TIME_W = 63;
    localparam int unsigned IVL_W = 48;
    localparam int unsigned ID_W = 32;
    localparam int unsigned CNT_W = 5;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef enum logic [1:0] {
        FUNC_INSERT   = 2'd0,
        FUNC_CANCEL   = 2'd1,
        FUNC_DISPATCH = 2'd2,
        FUNC_NONE     = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_INSERT,
        CMD_CANCEL,
        CMD_POP,
        CMD_COMPACT
    } cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAN,
        S_DISP,
        S_FIRE,
        S_COMPACT,
        S_REPLY
    } state_t;

    typedef struct packed {
        logic [TIME_W-1:0] expiry;
        logic [IVL_W-1:0]  interval;
        logic [ID_W-1:0]   id;
        logic              pending;
    } entry_t;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        cmd_t              cmd;
        entry_t            ins;
        logic [ID_W-1:0]   cancel_id;
    } bus_t;
endpackage
`default_nettype wire

/* sv/teq_cell.sv */
// ----------------------------------------------------------------------------
// Timer expiry queue cell
// One slot of the sorted chain; shifts towards either neighbour on command.
// ----------------------------------------------------------------------------
`default_nettype none
module teq_cell (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire teq_pkg::bus_t   bus,
    input  wire logic            used,       // this slot is below occupancy
    input  wire logic            prev_used,
    input  wire teq_pkg::entry_t prev_entry,
    input  wire logic            prev_after, // previous slot sorts after new entry
    input  wire logic            prev_hit,   // a cancel matched at a lower slot
    input  wire teq_pkg::entry_t next_entry,
    output teq_pkg::entry_t      entry,
    output logic                 after,
    output logic                 hit_out
);
    teq_pkg::entry_t entry_reg, entry_next;
    logic            hit;

    assign entry = entry_reg;
    assign after = used && ((entry_reg.expiry > bus.ins.expiry) ||
                   (entry_reg.expiry == bus.ins.expiry && entry_reg.id > bus.ins.id));
    assign hit   = used && entry_reg.pending && entry_reg.id == bus.cancel_id;
    assign hit_out  = prev_hit | hit;

    always_comb begin
        entry_next = entry_reg;
        unique case (bus.cmd)
            teq_pkg::CMD_INSERT: begin
                if (after) entry_next = prev_after ? prev_entry : bus.ins;
                else if (!used && !(prev_used && prev_after) && prev_used)
                    entry_next = bus.ins;
                else if (!used && prev_used && prev_after) entry_next = prev_entry;
            end
            teq_pkg::CMD_CANCEL: if (hit && !prev_hit) entry_next.pending = 1'b0;
            teq_pkg::CMD_POP: begin
                entry_next = next_entry;
                if (!used) entry_next.pending = 1'b0;
            end
            default: ;
        endcase
        if (!used && bus.cmd != teq_pkg::CMD_INSERT) entry_next.pending = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) entry_reg <= '0;
        else entry_reg <= entry_next;
    end
endmodule
`default_nettype wire

/* sv/timer_expiry_queue.sv */
// ----------------------------------------------------------------------------
// Timer expiry queue
// Sorted chain of timer cells with a small sequencer for insert, cancel and
// dispatch.
// ----------------------------------------------------------------------------
// Channel | Direction | Contents
// s_axis  | in        | tuser {func}, tdata {now, timer_id, interval, expiry}
// m_axis  | out       | tuser {fired}, tdata {work_count, result_id, status},
//         |           | tlast = last
//
// An insert, and a cancel that finds nothing, answer from the S_FIRE or
// S_CLEAN state after the input transfer. A cancel that hits passes through
// S_DISP, which drops dead front entries, S_COMPACT, which removes entries
// by compaction, and S_REPLY. A dispatch fires timers in S_DISP, periodic
// ones re-entering the chain through S_FIRE, then has the same clean-up and
// the closing count transfer. The cell chain shifts one place per cycle.
// Reset clears the pending bits, occupancy and the id counter. A stalled
// result holds the block; the next transfer is taken once it has gone.
// ----------------------------------------------------------------------------
`default_nettype none
module timer_expiry_queue #(
    parameter int unsigned DEPTH = teq_pkg::DEPTH_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [1:0]   s_tuser,  // func[1:0]
    // expiry[62:0], interval[110:63], timer_id[142:111], now[205:143]
    input  wire logic [207:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // status[1:0], result_id[33:2], work_count[38:34]
    output logic [39:0]       m_tdata,
    output logic              m_tuser,  // fired[0]
    output logic              m_tlast
);
    localparam int unsigned TW = teq_pkg::TIME_W;
    localparam int unsigned OW = $clog2(DEPTH + 1);

    teq_pkg::state_t state_reg, state_next;
    teq_pkg::func_t  func_reg, func_next;
    logic [TW-1:0]   now_reg, now_next;
    logic [OW-1:0]   occ_reg, occ_next, canc_reg, canc_next, work_reg, work_next;
    logic            pass_reg, pass_next;  // compaction decided for this item
    logic [31:0]     last_id_reg, last_id_next;
    teq_pkg::bus_t   bus;
    logic            out_v_reg, out_v_next, out_l_reg, out_l_next;
    logic [40:0]     out_d_reg, out_d_next;
    teq_pkg::entry_t ent [DEPTH+1];
    teq_pkg::entry_t ins_reg, ins_next;
    logic            aft [DEPTH+1];
    logic            hit [DEPTH+1];
    logic [31:0]     cid_reg, cid_next;

    assign aft[0] = 1'b0;
    assign hit[0] = 1'b0;

    // Chain of cells; for compaction a pop is issued on the first
    // non-pending entry via the popped-position shift below.
    logic [DEPTH-1:0] shift_from;  // cells at or above the hole shift down
    teq_pkg::entry_t  nxt [DEPTH];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        teq_pkg::bus_t cb;
        always_comb begin
            cb = bus;
            if (bus.cmd == teq_pkg::CMD_POP && !shift_from[i]) cb.cmd = teq_pkg::CMD_HOLD;
        end
        if (i == DEPTH - 1) begin : g_top
            assign nxt[i] = ent[i+1];
        end else begin : g_mid
            assign nxt[i] = ent[i+2];
        end
        teq_cell u_cell (
            .aclk(aclk), .aresetn(aresetn), .bus(cb),
            .used(OW'(i) < occ_reg),
            .prev_used(i == 0 ? 1'b1 : (OW'(i - 1) < occ_reg)),
            .prev_entry(ent[i]),
            .prev_after(aft[i]),
            .prev_hit(hit[i]),
            .next_entry(nxt[i]),
            .entry(ent[i+1]), .after(aft[i+1]),
            .hit_out(hit[i+1])
        );
    end
    assign ent[0] = ins_reg;

    // Mask of slots from the first non-pending one upward, for compaction one hole per cycle.
    logic [DEPTH-1:0] hole_seen;
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            hole_seen[i] = (OW'(i) < occ_reg) && !ent[i+1].pending;
            if (i > 0) hole_seen[i] = hole_seen[i] | hole_seen[i-1];
        end
    end

    logic [TW:0]    sum;
    logic [TW-1:0]  ne, nmin;
    logic           front_dead, due;

    always_comb begin
        sum   = {1'b0, ent[1].expiry} + {{(TW-teq_pkg::IVL_W+1){1'b0}}, ent[1].interval};
        ne    = sum[TW] ? teq_pkg::TIME_MAX : sum[TW-1:0];
        nmin  = (now_reg == teq_pkg::TIME_MAX) ? now_reg : now_reg + 1'b1;
        if (ne < nmin) ne = nmin;
        front_dead = (occ_reg != '0) && !ent[1].pending;
        due        = (occ_reg != '0) && ent[1].expiry <= now_reg;
    end

    assign s_tready = (state_reg == teq_pkg::S_IDLE) && !out_v_reg;
    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_d_reg[39:0];
    assign m_tuser  = out_d_reg[40];
    assign m_tlast  = out_l_reg;

    // The fired flag rides on top, above the padded data word.
    function automatic logic [40:0] pack(input teq_pkg::status_t st, input logic [31:0] id,
                                         input logic fi, input logic [4:0] wc);
        pack = {fi, 1'b0, wc, id, st};
    endfunction

    always_comb begin
        state_next   = state_reg;
        func_next    = func_reg;
        now_next     = now_reg;
        occ_next     = occ_reg;
        canc_next    = canc_reg;
        work_next    = work_reg;
        pass_next    = pass_reg;
        last_id_next = last_id_reg;
        ins_next     = ins_reg;
        cid_next     = cid_reg;
        out_v_next   = out_v_reg && !m_tready;
        out_d_next   = out_d_reg;
        out_l_next   = out_l_reg;
        bus.cmd      = teq_pkg::CMD_HOLD;
        bus.ins      = ins_reg;
        bus.cancel_id = cid_reg;
        shift_from   = '1;
        unique case (state_reg)
            teq_pkg::S_IDLE: if (s_tvalid && s_tready) begin
                func_next = teq_pkg::func_t'(s_tuser);
                now_next  = s_tdata[205:143];
                cid_next  = s_tdata[142:111];
                work_next = '0;
                unique case (teq_pkg::func_t'(s_tuser))
                    teq_pkg::FUNC_INSERT: begin
                        if (occ_reg == OW'(DEPTH)) begin
                            out_v_next = 1'b1; out_l_next = 1'b1;
                            out_d_next = pack(teq_pkg::ST_FULL, '0, 1'b0, '0);
                        end else begin
                            last_id_next = (last_id_reg == '1) ? 32'd1 : last_id_reg + 1'b1;
                            ins_next = '{expiry: s_tdata[62:0], interval: s_tdata[110:63],
                                         id: last_id_next, pending: 1'b1};
                            state_next = teq_pkg::S_FIRE;
                        end
                    end
                    teq_pkg::FUNC_CANCEL: state_next = teq_pkg::S_CLEAN;
                    teq_pkg::FUNC_DISPATCH: state_next = teq_pkg::S_DISP;
                    default: begin
                        out_v_next = 1'b1; out_l_next = 1'b1;
                        out_d_next = pack(teq_pkg::ST_OK, '0, 1'b0, '0);
                    end
                endcase
            end
            teq_pkg::S_FIRE: begin
                // Insert ins_reg into the sorted chain.
                bus.cmd  = teq_pkg::CMD_INSERT;
                occ_next = occ_reg + 1'b1;
                if (func_reg == teq_pkg::FUNC_INSERT) begin
                    out_v_next = 1'b1; out_l_next = 1'b1;
                    out_d_next = pack(teq_pkg::ST_OK, ins_reg.id, 1'b0, '0);
                    state_next = teq_pkg::S_IDLE;
                end else state_next = teq_pkg::S_DISP;
            end
            teq_pkg::S_CLEAN: begin
                bus.cmd = teq_pkg::CMD_CANCEL;
                if (!hit[DEPTH]) begin
                    out_v_next = 1'b1; out_l_next = 1'b1;
                    out_d_next = pack(teq_pkg::ST_NOT_FOUND, '0, 1'b0, '0);
                    state_next = teq_pkg::S_IDLE;
                end else begin
                    canc_next  = canc_reg + 1'b1;
                    state_next = teq_pkg::S_DISP;
                end
            end
            teq_pkg::S_DISP: begin
                if (front_dead) begin
                    bus.cmd  = teq_pkg::CMD_POP;
                    occ_next = occ_reg - 1'b1;
                    if (canc_reg != '0) canc_next = canc_reg - 1'b1;
                end else if (func_reg == teq_pkg::FUNC_DISPATCH && due &&
                             work_reg != OW'(DEPTH) && !out_v_reg) begin
                    bus.cmd    = teq_pkg::CMD_POP;
                    occ_next   = occ_reg - 1'b1;
                    work_next  = work_reg + 1'b1;
                    out_v_next = 1'b1; out_l_next = 1'b0;
                    out_d_next = pack(teq_pkg::ST_OK, ent[1].id, 1'b1, '0);
                    if (ent[1].interval != '0) begin
                        ins_next   = '{expiry: ne, interval: ent[1].interval,
                                       id: ent[1].id, pending: 1'b1};
                        state_next = teq_pkg::S_FIRE;
                    end
                end else if (!(func_reg == teq_pkg::FUNC_DISPATCH && due &&
                               work_reg != OW'(DEPTH))) begin
                    // The compaction decision is taken once, on the counts
                    // left after the front has been cleaned.
                    pass_next  = canc_reg > (occ_reg >> 1);
                    state_next = teq_pkg::S_COMPACT;
                end
            end
            teq_pkg::S_COMPACT: begin
                if (pass_reg && hole_seen[DEPTH-1]) begin
                    bus.cmd    = teq_pkg::CMD_POP;
                    shift_from = hole_seen;
                    occ_next   = occ_reg - 1'b1;
                    canc_next  = canc_reg - 1'b1;
                    if (canc_reg == OW'(1)) canc_next = '0;
                end else begin
                    if (pass_reg) canc_next = '0;
                    state_next = teq_pkg::S_REPLY;
                end
            end
            teq_pkg::S_REPLY: if (!out_v_reg) begin
                out_v_next = 1'b1; out_l_next = 1'b1;
                out_d_next = pack(teq_pkg::ST_OK, '0, 1'b0,
                    func_reg == teq_pkg::FUNC_DISPATCH ? 5'(work_reg) : 5'd0);
                state_next = teq_pkg::S_IDLE;
            end
            default: state_next = teq_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= teq_pkg::S_IDLE;
            occ_reg     <= '0;
            canc_reg    <= '0;
            last_id_reg <= '0;
            out_v_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            occ_reg     <= occ_next;
            canc_reg    <= canc_next;
            last_id_reg <= last_id_next;
            out_v_reg   <= out_v_next;
        end
        func_reg  <= func_next;
        now_reg   <= now_next;
        work_reg  <= work_next;
        pass_reg  <= pass_next;
        ins_reg   <= ins_next;
        cid_reg   <= cid_next;
        out_d_reg <= out_d_next;
        out_l_reg <= out_l_next;
    end

    a_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= OW'(DEPTH)) else $error("occupancy overflow");
    a_canc: assert property (@(posedge aclk) disable iff (!aresetn)
        canc_reg <= occ_reg) else $error("cancel count above occupancy");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != teq_pkg::S_IDLE |-> !s_tready) else $error("ready while busy");
endmodule
`default_nettype wire

/* bench/timer_expiry_queue_test.sv */
// ----------------------------------------------------------------------------
// Timer expiry queue testbench
// Drives inserts, cancels and dispatches into the queue and checks every
// result transfer against a sorted-list model of the timers held.
// ----------------------------------------------------------------------------
`default_nettype none

class expiry_board;
    localparam int DEPTH = teq_pkg::DEPTH_DEF;
    localparam logic [62:0] TMAX = {63{1'b1}};

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] rid;
        logic        fired;
        logic [4:0]  work;
        logic        last;
    } reply_t;

    logic [62:0] exp_q [DEPTH];
    logic [47:0] ivl_q [DEPTH];
    logic [31:0] id_q [DEPTH];
    bit          pend_q [DEPTH];
    int          held;
    int          cancelled;
    logic [31:0] next_id;
    reply_t      awaited [$];
    int          errors;
    int          fired_total;

    function new();
        held = 0;
        cancelled = 0;
        next_id = 0;
        errors = 0;
        fired_total = 0;
        for (int i = 0; i < DEPTH; i++) pend_q[i] = 0;
    endfunction

    function void add_reply(logic [1:0] st, logic [31:0] rid, logic f,
                            logic [4:0] w, logic l);
        reply_t r;
        r.status = st;
        r.rid = rid;
        r.fired = f;
        r.work = w;
        r.last = l;
        awaited.insert(awaited.size(), r);
    endfunction

    function void place(logic [62:0] e, logic [47:0] iv, logic [31:0] id);
        int p;
        p = held;
        while (p > 0 && (exp_q[p-1] > e || (exp_q[p-1] == e && id_q[p-1] > id))) begin
            exp_q[p] = exp_q[p-1];
            ivl_q[p] = ivl_q[p-1];
            id_q[p] = id_q[p-1];
            pend_q[p] = pend_q[p-1];
            p--;
        end
        exp_q[p] = e;
        ivl_q[p] = iv;
        id_q[p] = id;
        pend_q[p] = 1;
        held++;
    endfunction

    function void drop_front();
        for (int i = 1; i < held; i++) begin
            exp_q[i-1] = exp_q[i];
            ivl_q[i-1] = ivl_q[i];
            id_q[i-1] = id_q[i];
            pend_q[i-1] = pend_q[i];
        end
        held--;
        pend_q[held] = 0;
    endfunction

    function void clean_front();
        while (held > 0 && !pend_q[0]) begin
            drop_front();
            if (cancelled > 0) cancelled--;
        end
    endfunction

    function void squeeze();
        int w;
        w = 0;
        if (cancelled <= held / 2) return;
        for (int i = 0; i < held; i++) begin
            if (pend_q[i]) begin
                exp_q[w] = exp_q[i];
                ivl_q[w] = ivl_q[i];
                id_q[w] = id_q[i];
                pend_q[w] = 1;
                w++;
            end
        end
        for (int i = w; i < held; i++) pend_q[i] = 0;
        held = w;
        cancelled = 0;
    endfunction

    // Works out the replies that one accepted input transfer causes.
    function void note_input(teq_pkg::func_t fn, logic [62:0] e, logic [47:0] iv,
                             logic [31:0] tid, logic [62:0] now);
        bit found;
        int work;
        logic [62:0] floor_t, ce, ne;
        logic [47:0] civ;
        logic [31:0] cid;
        logic [63:0] sum;
        case (fn)
            teq_pkg::FUNC_INSERT: begin
                if (held >= DEPTH) begin
                    add_reply(teq_pkg::ST_FULL, 0, 0, 0, 1);
                end else begin
                    next_id = next_id + 1;
                    if (next_id == 0) next_id = 1;
                    place(e, iv, next_id);
                    add_reply(teq_pkg::ST_OK, next_id, 0, 0, 1);
                end
            end
            teq_pkg::FUNC_CANCEL: begin
                found = 0;
                for (int i = 0; i < held && !found; i++) begin
                    if (pend_q[i] && id_q[i] == tid) begin
                        pend_q[i] = 0;
                        found = 1;
                    end
                end
                if (!found) begin
                    add_reply(teq_pkg::ST_NOT_FOUND, 0, 0, 0, 1);
                end else begin
                    cancelled++;
                    clean_front();
                    squeeze();
                    add_reply(teq_pkg::ST_OK, 0, 0, 0, 1);
                end
            end
            teq_pkg::FUNC_DISPATCH: begin
                work = 0;
                floor_t = (now < TMAX) ? now + 63'd1 : TMAX;
                forever begin
                    clean_front();
                    if (held == 0 || work >= DEPTH || exp_q[0] > now) break;
                    ce = exp_q[0];
                    civ = ivl_q[0];
                    cid = id_q[0];
                    drop_front();
                    add_reply(teq_pkg::ST_OK, cid, 1, 0, 0);
                    work++;
                    fired_total++;
                    if (civ != 0) begin
                        sum = {1'b0, ce} + {16'd0, civ};
                        ne = sum[63] ? TMAX : sum[62:0];
                        if (ne < floor_t) ne = floor_t;
                        place(ne, civ, cid);
                    end
                end
                squeeze();
                add_reply(teq_pkg::ST_OK, 0, 0, 5'(work), 1);
            end
            default: add_reply(teq_pkg::ST_OK, 0, 0, 0, 1);
        endcase
    endfunction

    function void check_reply(logic [39:0] d, logic u, logic l);
        reply_t x;
        if (awaited.size() == 0) begin
            $error("unexpected result transfer %h", d);
            errors++;
            return;
        end
        x = awaited.pop_front();
        if (d[1:0] !== x.status) begin
            $error("status expected %0d actual %0d", x.status, d[1:0]);
            errors++;
        end
        if (d[33:2] !== x.rid) begin
            $error("result_id expected %0d actual %0d", x.rid, d[33:2]);
            errors++;
        end
        if (u !== x.fired) begin
            $error("fired expected %0d actual %0d", x.fired, u);
            errors++;
        end
        if (d[38:34] !== x.work) begin
            $error("work_count expected %0d actual %0d", x.work, d[38:34]);
            errors++;
        end
        if (l !== x.last) begin
            $error("last expected %0d actual %0d", x.last, l);
            errors++;
        end
    endfunction
endclass

module timer_expiry_queue_test;
    localparam logic [62:0] TOP_T = {63{1'b1}};
    localparam int CYCLE_LIMIT = 400000;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [1:0]   s_tuser = '0;
    logic [207:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [39:0]  m_tdata;
    logic         m_tuser;
    logic         m_tlast;

    expiry_board board = new();
    int  cycles = 0;
    int  sent = 0;
    bit  calm = 0;   // no idling on either side while set
    logic [62:0] clock_ns = 1000;

    timer_expiry_queue dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    always begin
        #2 aclk = 1;
        #2 aclk = 0;
    end

    // Cycle counter with a generous ceiling as a hang guard.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Result side: random back-pressure, and every transfer is checked.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_reply(m_tdata, m_tuser, m_tlast);
        m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 27);
    end

    // One input transfer, with an optional idle gap before it. Valid stays
    // high after an acceptance when the next transfer follows at once.
    task automatic send(teq_pkg::func_t fn, logic [62:0] e, logic [47:0] iv,
                        logic [31:0] tid, logic [62:0] now);
        while (!calm && $urandom_range(99) < 27) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= {2'b00, now, tid, iv, e};
        do @(posedge aclk); while (!s_tready);
        board.note_input(fn, e, iv, tid, now);
        sent++;
    endtask

    function automatic logic [62:0] any_time();
        return 63'({$urandom, $urandom});
    endfunction

    // Picks an id that is likely to be held, now and then a stray one.
    function automatic logic [31:0] some_id();
        if (board.held > 0 && $urandom_range(9) < 8)
            return board.id_q[$urandom_range(board.held - 1)];
        return ($urandom_range(9) < 5) ? board.next_id + 32'd1 : $urandom;
    endfunction

    task automatic random_item();
        int pick;
        logic [47:0] iv;
        logic [62:0] e;
        pick = $urandom_range(99);
        if (pick < 45) begin
            case ($urandom_range(3))
                0: iv = '0;
                1: iv = 48'($urandom_range(1, 400));
                2: iv = 48'({$urandom, $urandom});
                default: iv = 48'($urandom_range(1, 50));
            endcase
            e = ($urandom_range(9) == 0) ? any_time()
                : clock_ns + 63'($urandom_range(0, 300));
            send(teq_pkg::FUNC_INSERT, e, iv, $urandom, '0);
        end else if (pick < 70) begin
            send(teq_pkg::FUNC_CANCEL, any_time(), 48'({$urandom, $urandom}),
                 some_id(), any_time());
        end else if (pick < 97) begin
            clock_ns = clock_ns + 63'($urandom_range(0, 120));
            send(teq_pkg::FUNC_DISPATCH, any_time(), 48'({$urandom, $urandom}), $urandom,
                 ($urandom_range(19) == 0) ? any_time() : clock_ns);
        end else begin
            send(teq_pkg::FUNC_NONE, any_time(), 48'({$urandom, $urandom}), $urandom,
                 any_time());
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed part: field extremes, full queue, ties, cancels, saturation.
        send(teq_pkg::FUNC_CANCEL, '0, '0, 32'd1, '0);
        send(teq_pkg::FUNC_DISPATCH, '0, '0, '0, '0);
        send(teq_pkg::FUNC_INSERT, '0, '0, '0, '0);
        send(teq_pkg::FUNC_INSERT, TOP_T, {48{1'b1}}, '1, TOP_T);
        for (int i = 0; i < 14; i++)
            send(teq_pkg::FUNC_INSERT, 63'd50, ((i % 2) != 0) ? 48'd10 : 48'd0, '0, '0);
        send(teq_pkg::FUNC_INSERT, 63'd5, '0, '0, '0);
        send(teq_pkg::FUNC_CANCEL, '0, '0, 32'd7, '0);
        send(teq_pkg::FUNC_CANCEL, '0, '0, 32'd7, '0);
        send(teq_pkg::FUNC_CANCEL, '0, '0, 32'hFFFF_FFFF, '0);
        send(teq_pkg::FUNC_DISPATCH, '0, '0, '0, 63'd60);
        send(teq_pkg::FUNC_NONE, TOP_T, {48{1'b1}}, '1, TOP_T);
        send(teq_pkg::FUNC_DISPATCH, '0, '0, '0, TOP_T);

        // Random part, with a calm stretch in the middle.
        for (int n = 0; n < 470; n++) begin
            calm = (n >= 200 && n < 260);
            random_item();
        end
        calm = 0;
        s_tvalid <= 1'b0;

        while (board.awaited.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        $display("Sent %0d input transfers; %0d timer expiries predicted and checked.",
                 sent, board.fired_total);
        if (board.errors == 0 && board.awaited.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

`default_nettype wire

/* sim.f */
sv/teq_pkg.sv
sv/teq_cell.sv
sv/timer_expiry_queue.sv
bench/timer_expiry_queue_test.sv
